/* rtl/idle_timeout_list_unit_defines.svh */
// Assertion macros shared by the idle timeout list modules.
`ifndef IDLE_TIMEOUT_LIST_UNIT_DEFINES_SVH
`define IDLE_TIMEOUT_LIST_UNIT_DEFINES_SVH
// Property that must hold in the cycle after a trigger.
`define ITL_ASSERT_NEXT(lbl, clk, rst, trig, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
      else $error("assertion failed");
// Property that must hold in the same cycle as a trigger.
`define ITL_ASSERT_SAME(lbl, clk, rst, trig, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
      else $error("assertion failed");
`endif

/* rtl/itl_pkg.sv */
// Shared types and constants of the idle timeout list.
`default_nettype none
package itl_pkg;
   localparam int Slots = 256;
   localparam int SlotW = $clog2(Slots);
   localparam int LinkW = SlotW + 1;
   localparam int Usable = (Slots < 256) ? Slots : 256;
   localparam logic [LinkW-1:0] Nil = LinkW'(Slots);
   localparam logic [30:0] Max31 = 31'h7fffffff;

   localparam logic [2:0] OpSetTime = 3'd0;
   localparam logic [2:0] OpNew = 3'd1;
   localparam logic [2:0] OpRemove = 3'd2;
   localparam logic [2:0] OpRefresh = 3'd3;
   localparam logic [2:0] OpPoll = 3'd4;

   localparam logic [2:0] StOk = 3'd0;
   localparam logic [2:0] StBackwards = 3'd1;
   localparam logic [2:0] StFull = 3'd2;
   localparam logic [2:0] StBadHandle = 3'd3;
   localparam logic [2:0] StNotAlloc = 3'd4;
   localparam logic [2:0] StNoneExpired = 3'd5;

   typedef struct packed {
      logic latch;   // capture request fields
      logic decide;  // evaluate checks
      logic commit;  // write memories and pointers
      logic finish;  // load the response register, link the slot as newest
   } cmd_type;

   typedef struct packed {
      logic busy_out;  // response register full and stalled
   } sts_type;
endpackage
`default_nettype wire

/* rtl/itl_ctrl.sv */
// Controller state machine of the idle timeout list.
`default_nettype none
`include "idle_timeout_list_unit_defines.svh"
module itl_ctrl (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_stall,
   input wire itl_pkg::sts_type sts,
   output itl_pkg::cmd_type cmd
);
   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_READ = 5'b00010,
      S_DECIDE = 5'b00100,
      S_COMMIT = 5'b01000,
      S_DONE = 5'b10000
   } state_type;
   state_type state_ff, state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in = S_READ;
            end
         end
         S_READ: state_in = S_DECIDE;
         S_DECIDE: begin
            cmd.decide = 1'b1;
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            if (!sts.busy_out) begin
               cmd.commit = 1'b1;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            cmd.finish = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   `ITL_ASSERT_NEXT(a_latch_read, clock, reset, cmd.latch, state_ff == S_READ)
   `ITL_ASSERT_NEXT(a_commit_done, clock, reset, cmd.commit, cmd.finish)
   `ITL_ASSERT_SAME(a_busy_stall, clock, reset, state_ff != S_IDLE, req_stall)
endmodule
`default_nettype wire

/* rtl/itl_datapath.sv */
// Slot memories, list pointers and response register of the idle timeout list.
`default_nettype none
`include "idle_timeout_list_unit_defines.svh"
module itl_datapath (
   input wire logic clock,
   input wire logic reset,
   input wire itl_pkg::cmd_type cmd,
   output itl_pkg::sts_type sts,
   input wire logic [2:0] req_op,
   input wire logic [30:0] req_new_time,
   input wire logic [7:0] req_handle,
   input wire logic signed [31:0] req_tag,
   input wire logic csr_valid,
   input wire logic [30:0] csr_timeout_ticks,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output logic [2:0] rsp_status,
   output logic [7:0] rsp_out_handle,
   output logic signed [31:0] rsp_out_tag
);
   localparam int SW = itl_pkg::SlotW;
   localparam int LW = itl_pkg::LinkW;

   logic [30:0] deadline_mem [itl_pkg::Slots];
   logic [31:0] tag_mem [itl_pkg::Slots];
   logic [LW-1:0] older_mem [itl_pkg::Slots];
   logic [LW-1:0] newer_mem [itl_pkg::Slots];
   logic [itl_pkg::Slots-1:0] in_use_ff;

   logic [30:0] timeout_ff, now_ff;
   logic [LW-1:0] newest_ff, oldest_ff;
   logic [2:0] op_ff;
   logic [30:0] time_ff;
   logic [7:0] handle_ff;
   logic [31:0] tag_ff;
   logic [SW-1:0] slot_ff;
   logic slot_ok_ff;
   logic [30:0] dl_rd_ff;
   logic [31:0] tag_rd_ff;
   logic [LW-1:0] old_rd_ff, new_rd_ff;
   logic [2:0] status_ff;
   logic [7:0] oh_ff;
   logic [31:0] ot_ff;
   logic act_ff, unlink_ff, link_ff, free_ff, alloc_ff;
   logic rsp_valid_ff;
   logic [2:0] res_status_ff;
   logic [7:0] res_handle_ff;
   logic [31:0] res_tag_ff;
   logic state_read, latch_d_ff;

   logic [SW-1:0] target;
   logic [SW-1:0] free_idx;
   logic free_found;
   logic [31:0] dl_sum;
   logic [30:0] dl_new;
   logic [SW-1:0] slot_in;

   always_comb begin
      free_idx = '0;
      free_found = 1'b0;
      for (int i = itl_pkg::Usable - 1; i >= 0; i--) begin
         if (!in_use_ff[i]) begin
            free_idx = SW'(i);
            free_found = 1'b1;
         end
      end
   end

   assign dl_sum = {1'b0, now_ff} + {1'b0, timeout_ff};
   assign dl_new = dl_sum[31] ? itl_pkg::Max31 : dl_sum[30:0];
   assign target = (op_ff == itl_pkg::OpPoll) ? oldest_ff[SW-1:0] : handle_ff[SW-1:0];

   always_comb begin
      slot_in = target;
      if (op_ff == itl_pkg::OpNew) slot_in = free_idx;
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff <= req_op;
         time_ff <= req_new_time;
         handle_ff <= req_handle;
         tag_ff <= req_tag;
      end
      if (state_read) begin
         slot_ff <= slot_in;
         slot_ok_ff <= free_found;
         dl_rd_ff <= deadline_mem[target];
         tag_rd_ff <= tag_mem[target];
         old_rd_ff <= older_mem[target];
         new_rd_ff <= newer_mem[target];
      end
   end

   // The read cycle follows the latch cycle.
   assign state_read = latch_d_ff;

   logic hok, alloc_h;
   assign hok = ({1'b0, handle_ff} < 9'(itl_pkg::Slots));
   assign alloc_h = hok && in_use_ff[handle_ff[SW-1:0]];

   always_ff @(posedge clock) begin
      if (cmd.decide) begin
         status_ff <= itl_pkg::StOk;
         oh_ff <= '0;
         ot_ff <= '0;
         unlink_ff <= 1'b0;
         link_ff <= 1'b0;
         free_ff <= 1'b0;
         alloc_ff <= 1'b0;
         act_ff <= 1'b0;
         unique case (op_ff)
            itl_pkg::OpSetTime: begin
               if (time_ff < now_ff) status_ff <= itl_pkg::StBackwards;
               else act_ff <= 1'b1;
            end
            itl_pkg::OpNew: begin
               if (!slot_ok_ff) status_ff <= itl_pkg::StFull;
               else begin
                  alloc_ff <= 1'b1;
                  link_ff <= 1'b1;
                  oh_ff <= 8'(slot_ff);
               end
            end
            itl_pkg::OpRemove: begin
               if (!alloc_h) status_ff <= itl_pkg::StBadHandle;
               else begin
                  unlink_ff <= 1'b1;
                  free_ff <= 1'b1;
               end
            end
            itl_pkg::OpRefresh: begin
               if (!hok) status_ff <= itl_pkg::StBadHandle;
               else if (!alloc_h) status_ff <= itl_pkg::StNotAlloc;
               else begin
                  unlink_ff <= 1'b1;
                  link_ff <= 1'b1;
               end
            end
            itl_pkg::OpPoll: begin
               if (oldest_ff == itl_pkg::Nil || now_ff < dl_rd_ff)
                  status_ff <= itl_pkg::StNoneExpired;
               else begin
                  unlink_ff <= 1'b1;
                  free_ff <= 1'b1;
                  oh_ff <= 8'(slot_ff);
                  ot_ff <= tag_rd_ff;
               end
            end
            default: ;
         endcase
      end
   end

   // Unlink happens at commit and relink at finish; the head after unlink is computed here.
   logic [LW-1:0] o, w, nw_after, od_after, slot_l;
   assign o = old_rd_ff;
   assign w = new_rd_ff;
   assign slot_l = LW'(slot_ff);
   assign nw_after = (unlink_ff && w == itl_pkg::Nil) ? o : newest_ff;
   assign od_after = (unlink_ff && o == itl_pkg::Nil) ? w : oldest_ff;

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         if (unlink_ff) begin
            if (o != itl_pkg::Nil) newer_mem[o[SW-1:0]] <= w;
            if (w != itl_pkg::Nil) older_mem[w[SW-1:0]] <= o;
         end
         if (alloc_ff) tag_mem[slot_ff] <= tag_ff;
         if (link_ff) deadline_mem[slot_ff] <= dl_new;
      end
      if (cmd.finish && link_ff) begin
         older_mem[slot_ff] <= newest_ff;
         newer_mem[slot_ff] <= itl_pkg::Nil;
         if (newest_ff != itl_pkg::Nil) newer_mem[newest_ff[SW-1:0]] <= slot_l;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= 31'd1;
         now_ff <= '0;
         newest_ff <= itl_pkg::Nil;
         oldest_ff <= itl_pkg::Nil;
         in_use_ff <= '0;
         rsp_valid_ff <= 1'b0;
         latch_d_ff <= 1'b0;
      end else begin
         latch_d_ff <= cmd.latch;
         if (csr_valid) timeout_ff <= csr_timeout_ticks;
         if (cmd.commit) begin
            if (act_ff) now_ff <= time_ff;
            newest_ff <= nw_after;
            oldest_ff <= od_after;
            if (alloc_ff) in_use_ff[slot_ff] <= 1'b1;
            if (free_ff) in_use_ff[slot_ff] <= 1'b0;
         end
         if (cmd.finish && link_ff) begin
            newest_ff <= slot_l;
            if (oldest_ff == itl_pkg::Nil) oldest_ff <= slot_l;
         end
         if (cmd.finish) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         res_status_ff <= status_ff;
         res_handle_ff <= oh_ff;
         res_tag_ff <= ot_ff;
      end
   end

   assign sts.busy_out = rsp_valid_ff && rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = res_status_ff;
   assign rsp_out_handle = res_handle_ff;
   assign rsp_out_tag = res_tag_ff;

   `ITL_ASSERT_NEXT(a_fin_valid, clock, reset, cmd.finish, rsp_valid_ff)
   `ITL_ASSERT_SAME(a_list_ends, clock, reset, 1'b1,
      (newest_ff == itl_pkg::Nil) == (oldest_ff == itl_pkg::Nil))
   `ITL_ASSERT_SAME(a_alloc_free, clock, reset, cmd.commit, !(alloc_ff && free_ff))
endmodule
`default_nettype wire

/* rtl/idle_timeout_list_unit.sv */
// Top level of the idle timeout list: a pool of timers sharing one timeout.
//   channel  direction  handshake
//   req      in         req_valid / req_stall
//   rsp      out        rsp_valid / rsp_stall
//   csr      in         csr_valid / csr_ready
// Each word steps through latch, memory read, decide, commit and respond before the next is taken.
// A stalled response holds the commit step until the output register frees.
// Reset is synchronous; the timeout register resets to one, the list to empty.
`default_nettype none
module idle_timeout_list_unit (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_stall,
   input wire logic [2:0] req_op,
   input wire logic [30:0] req_new_time,
   input wire logic [7:0] req_handle,
   input wire logic signed [31:0] req_tag,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output logic [2:0] rsp_status,
   output logic [7:0] rsp_out_handle,
   output logic signed [31:0] rsp_out_tag,
   input wire logic csr_valid,
   output logic csr_ready,
   input wire logic [30:0] csr_timeout_ticks
);
   itl_pkg::cmd_type cmd;
   itl_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   itl_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .sts(sts), .cmd(cmd)
   );

   itl_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .req_op(req_op), .req_new_time(req_new_time), .req_handle(req_handle),
      .req_tag(req_tag), .csr_valid(csr_valid), .csr_timeout_ticks(csr_timeout_ticks),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_out_handle(rsp_out_handle), .rsp_out_tag(rsp_out_tag)
   );
endmodule
`default_nettype wire
